// ===== rtl/image_header_dimension_parser_top_defines.svh =====
// image_header_dimension_parser_top_defines.svh
// assertion macros shared by the image header parser checker
// no dependencies
`ifndef IMAGE_HEADER_DIMENSION_PARSER_TOP_DEFINES_SVH
`define IMAGE_HEADER_DIMENSION_PARSER_TOP_DEFINES_SVH

// same-cycle implication
`define IHDP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ihdp assertion failed");

// next-cycle implication
`define IHDP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ihdp assertion failed");

`endif

// ===== rtl/ihdp_pkg.sv =====
// ihdp_pkg.sv
// types, constants and signature tables for the image header dimension parser
// no dependencies
package ihdp_pkg;

  localparam int MinSize  = 24;
  localparam int ChunkHdr = 12;

  localparam logic [7:0] MarkerPrefix = 8'hFF;
  localparam logic [7:0] MarkerSof0   = 8'hC0;
  localparam logic [7:0] MarkerSofF   = 8'hCF;
  localparam logic [7:0] MarkerDht    = 8'hC4;
  localparam logic [7:0] MarkerJpg    = 8'hC8;
  localparam logic [7:0] MarkerDac    = 8'hCC;
  localparam logic [7:0] MarkerRst0   = 8'hD0;
  localparam logic [7:0] MarkerEoi    = 8'hD9;
  localparam logic [7:0] MarkerDri    = 8'hDD;

  typedef enum logic [1:0] {
    FmtGif  = 2'd0,
    FmtPng  = 2'd1,
    FmtJpeg = 2'd2,
    FmtNone = 2'd3
  } fmt_e;

  function automatic logic [7:0] gif_sig_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h47;
      2'd1:    r = 8'h49;
      2'd2:    r = 8'h46;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] jpeg_sig_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'hFF;
      2'd1:    r = 8'hD8;
      2'd2:    r = 8'hFF;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] png_sig_byte(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = 8'h89;
      4'd1:    r = 8'h50;
      4'd2:    r = 8'h4E;
      4'd3:    r = 8'h47;
      4'd4:    r = 8'h0D;
      4'd5:    r = 8'h0A;
      4'd6:    r = 8'h1A;
      4'd7:    r = 8'h0A;
      4'd12:   r = 8'h49;
      4'd13:   r = 8'h48;
      4'd14:   r = 8'h44;
      4'd15:   r = 8'h52;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // bytes 8..11 hold the ihdr length and are not checked
  function automatic logic png_sig_care(input logic [3:0] idx);
    return !(idx >= 4'd8 && idx <= 4'd11);
  endfunction

endpackage

// ===== rtl/image_header_dimension_parser_top.sv =====
// image_header_dimension_parser_top.sv
// byte-serial gif / png / jpeg dimension sniffer, single module
// depends on ihdp_pkg
//
// Takes one file byte per transaction, with last_byte_i on the final byte, and
// returns exactly one result transaction per file: found with format and sizes,
// or failure (format none, zero sizes). A byte is taken every clock while the
// result register is empty or being drained; the result of a byte appears in
// the result register in the cycle after its transaction, so throughput is one
// byte per clock while not stalled, set by the single result register.
// Signature checks are running match flags, the jpeg walk uses an 11-byte
// shift window and a precomputed chunk end offset, and the position counter
// saturates at POSITION_BITS ones.
module image_header_dimension_parser_top #(
  parameter int POSITION_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [1:0]  image_format_o,
  output logic [31:0] image_width_o,
  output logic [31:0] image_height_o
);
  import ihdp_pkg::*;

  localparam int PW = POSITION_BITS;
  localparam logic [PW-1:0] PosMax       = {PW{1'b1}};
  localparam logic [PW:0]   PosMaxExt    = {1'b0, PosMax};
  localparam logic [PW-1:0] PosMinSize   = PW'(MinSize);
  localparam logic [PW-1:0] PosLastHdr   = PW'(MinSize - 1);
  localparam logic [PW-1:0] PosSigEnd    = PW'(3);
  localparam logic [PW-1:0] PosPngEnd    = PW'(16);
  localparam logic [PW-1:0] PosTwo       = PW'(2);
  localparam logic [PW-1:0] ChunkEndInit = PW'(2 + ChunkHdr - 1);

  logic          in_fire;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] chunk_end_q, chunk_end_d;
  logic          gif_ok_q, gif_ok_d;
  logic          png_ok_q, png_ok_d;
  logic          jpeg_ok_q, jpeg_ok_d;
  logic          pend_q, pend_d;
  logic [15:0]   pend_w_q, pend_w_d;
  logic [15:0]   pend_h_q, pend_h_d;
  logic          given_q, given_d;

  logic [7:0]    hdr_q [MinSize];
  logic [7:0]    win_q [ChunkHdr-1];
  logic [7:0]    win   [ChunkHdr];

  logic          emit;
  logic          r_found;
  fmt_e          r_fmt;
  logic [31:0]   r_w, r_h;

  logic          out_valid_q;
  logic          found_q;
  fmt_e          fmt_q;
  logic [31:0]   width_q, height_q;

  logic          early;
  logic          sof;
  logic [16:0]   step_len;
  logic [PW:0]   next_end;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    for (int k = 0; k < ChunkHdr - 1; k++) begin
      win[k] = win_q[k];
    end
    win[ChunkHdr-1] = data_byte_i;
  end

  always_comb begin
    pos_d       = pos_q;
    chunk_end_d = chunk_end_q;
    gif_ok_d    = gif_ok_q;
    png_ok_d    = png_ok_q;
    jpeg_ok_d   = jpeg_ok_q;
    pend_d      = pend_q;
    pend_w_d    = pend_w_q;
    pend_h_d    = pend_h_q;
    given_d     = given_q;
    emit        = 1'b0;
    r_found     = 1'b0;
    r_fmt       = FmtNone;
    r_w         = '0;
    r_h         = '0;
    step_len    = '0;
    next_end    = '0;
    early       = pos_q < PosMinSize;
    sof         = (win[1] >= MarkerSof0) && (win[1] <= MarkerSofF) &&
                  (win[1] != MarkerDht) && (win[1] != MarkerJpg) && (win[1] != MarkerDac);

    if (in_fire) begin
      gif_ok_d  = gif_ok_q &&
                  (pos_q >= PosSigEnd || data_byte_i == gif_sig_byte(pos_q[1:0]));
      jpeg_ok_d = jpeg_ok_q &&
                  (pos_q >= PosSigEnd || data_byte_i == jpeg_sig_byte(pos_q[1:0]));
      png_ok_d  = png_ok_q &&
                  (pos_q >= PosPngEnd || !png_sig_care(pos_q[3:0]) ||
                   data_byte_i == png_sig_byte(pos_q[3:0]));

      if (!given_q) begin
        if (early && !gif_ok_d && !png_ok_d && !jpeg_ok_d) begin
          emit = 1'b1;
        end else begin
          if (jpeg_ok_d && pos_q >= PosTwo && !pend_q && pos_q == chunk_end_q) begin
            if (win[0] != MarkerPrefix) begin
              emit = 1'b1;
            end else if (sof) begin
              if (pos_q >= PosLastHdr) begin
                emit    = 1'b1;
                r_found = 1'b1;
                r_fmt   = FmtJpeg;
                r_w     = {16'h0, win[7], win[8]};
                r_h     = {16'h0, win[5], win[6]};
              end else begin
                pend_d   = 1'b1;
                pend_w_d = {win[7], win[8]};
                pend_h_d = {win[5], win[6]};
              end
            end else begin
              if (win[1] >= MarkerRst0 && win[1] <= MarkerEoi) begin
                step_len = 17'd2;
              end else if (win[1] == MarkerDri) begin
                step_len = 17'd6;
              end else begin
                step_len = 17'd2 + {1'b0, win[2], win[3]};
              end
              next_end = {1'b0, chunk_end_q} + (PW+1)'(step_len);
              if (next_end >= PosMaxExt) begin
                emit = 1'b1;
              end else begin
                chunk_end_d = next_end[PW-1:0];
              end
            end
          end
          if (!emit && pos_q == PosLastHdr) begin
            if (jpeg_ok_d) begin
              if (pend_q) begin
                emit    = 1'b1;
                r_found = 1'b1;
                r_fmt   = FmtJpeg;
                r_w     = {16'h0, pend_w_q};
                r_h     = {16'h0, pend_h_q};
              end
            end else if (gif_ok_d) begin
              emit    = 1'b1;
              r_found = 1'b1;
              r_fmt   = FmtGif;
              r_w     = {16'h0, hdr_q[7], hdr_q[6]};
              r_h     = {16'h0, hdr_q[9], hdr_q[8]};
            end else if (png_ok_d) begin
              emit    = 1'b1;
              r_found = 1'b1;
              r_fmt   = FmtPng;
              r_w     = {hdr_q[16], hdr_q[17], hdr_q[18], hdr_q[19]};
              r_h     = {hdr_q[20], hdr_q[21], hdr_q[22], data_byte_i};
            end else begin
              emit = 1'b1;
            end
          end
        end
      end

      if (last_byte_i) begin
        if (!given_q && !emit) begin
          emit = 1'b1;
        end
        pos_d       = '0;
        chunk_end_d = ChunkEndInit;
        gif_ok_d    = 1'b1;
        png_ok_d    = 1'b1;
        jpeg_ok_d   = 1'b1;
        pend_d      = 1'b0;
        pend_w_d    = '0;
        pend_h_d    = '0;
        given_d     = 1'b0;
      end else begin
        given_d = given_q || emit;
        if (pos_q != PosMax) begin
          pos_d = pos_q + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      chunk_end_q <= ChunkEndInit;
      gif_ok_q    <= 1'b1;
      png_ok_q    <= 1'b1;
      jpeg_ok_q   <= 1'b1;
      pend_q      <= 1'b0;
      pend_w_q    <= '0;
      pend_h_q    <= '0;
      given_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      chunk_end_q <= chunk_end_d;
      gif_ok_q    <= gif_ok_d;
      png_ok_q    <= png_ok_d;
      jpeg_ok_q   <= jpeg_ok_d;
      pend_q      <= pend_d;
      pend_w_q    <= pend_w_d;
      pend_h_q    <= pend_h_d;
      given_q     <= given_d;
      if (in_fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (early) begin
        hdr_q[pos_q[4:0]] <= data_byte_i;
      end
      for (int k = 0; k < ChunkHdr - 1; k++) begin
        win_q[k] <= win[k+1];
      end
    end
    if (in_fire && emit) begin
      found_q  <= r_found;
      fmt_q    <= r_fmt;
      width_q  <= r_w;
      height_q <= r_h;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign image_format_o = fmt_q;
  assign image_width_o  = width_q;
  assign image_height_o = height_q;

endmodule

// ===== rtl/ihdp_checker.sv =====
// ihdp_checker.sv
// port-level checks for image_header_dimension_parser_top, bound to the top
// depends on ihdp_pkg and image_header_dimension_parser_top_defines.svh
`include "image_header_dimension_parser_top_defines.svh"

module ihdp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  data_byte_i,
  input logic        last_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        found_o,
  input logic [1:0]  image_format_o,
  input logic [31:0] image_width_o,
  input logic [31:0] image_height_o
);
  import ihdp_pkg::*;

  logic        fail_shape;
  logic        narrow_size;
  logic        found_not_png;
  logic        out_stall;
  logic [66:0] out_bus;

  assign fail_shape    = (image_format_o == FmtNone) && (image_width_o == '0) &&
                         (image_height_o == '0);
  assign narrow_size   = (image_width_o[31:16] == 16'h0) && (image_height_o[31:16] == 16'h0);
  assign found_not_png = out_valid_o && found_o && (image_format_o != FmtPng);
  assign out_stall     = out_valid_o && !out_ready_i;
  assign out_bus       = {found_o, image_format_o, image_width_o, image_height_o};

  `IHDP_ASSERT_NOW(a_fail_zero, clk_i, rst_ni, out_valid_o && !found_o, fail_shape)
  `IHDP_ASSERT_NOW(a_found_fmt, clk_i, rst_ni, out_valid_o && found_o, image_format_o != FmtNone)
  `IHDP_ASSERT_NOW(a_short_dims, clk_i, rst_ni, found_not_png, narrow_size)
  `IHDP_ASSERT_NOW(a_ready_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)
  `IHDP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_bus))

endmodule

bind image_header_dimension_parser_top ihdp_checker u_ihdp_checker (.*);

// ===== sim/ihdp_result_checker.sv =====
// ihdp_result_checker.sv
// watches the byte and result channels of image_header_dimension_parser_top, predicts
// one result per file and compares every result transaction; depends on ihdp_pkg
module ihdp_result_checker #(
  parameter int POSITION_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        found_i,
  input  logic [1:0]  image_format_i,
  input  logic [31:0] image_width_i,
  input  logic [31:0] image_height_i,
  output int unsigned mismatches_o,
  output int unsigned pending_results_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ihdp_pkg::*;

  localparam longint unsigned PosMax = (64'd1 << POSITION_BITS) - 64'd1;
  localparam logic [23:0]  GifSig  = 24'h474946;
  localparam logic [23:0]  JpegSig = 24'hFFD8FF;
  localparam logic [127:0] PngSig  = 128'h89504E470D0A1A0A0000000049484452;
  localparam logic [15:0]  PngCare = 16'hFF0F;

  typedef struct packed {
    logic        found;
    fmt_e        fmt;
    logic [31:0] width;
    logic [31:0] height;
  } dims_t;

  logic [7:0]      hdr_bytes [MinSize];
  logic [7:0]      chunk_win [ChunkHdr];
  longint unsigned byte_pos;
  longint unsigned chunk_start;
  logic            sof_held;
  logic [15:0]     held_w;
  logic [15:0]     held_h;
  logic            file_done;
  dims_t           dims_q [$];
  int unsigned     err_count;

  function automatic dims_t make_dims(input logic f, input fmt_e fm,
                                      input logic [31:0] w, input logic [31:0] h);
    dims_t d;
    d.found  = f;
    d.fmt    = fm;
    d.width  = w;
    d.height = h;
    return d;
  endfunction

  task automatic restart_file();
    byte_pos    = 0;
    chunk_start = 2;
    sof_held    = 1'b0;
    held_w      = '0;
    held_h      = '0;
    file_done   = 1'b0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic l);
    longint unsigned p;
    longint unsigned span;
    longint unsigned nxt;
    logic            gif_ok;
    logic            png_ok;
    logic            jpeg_ok;
    logic            emit;
    logic [7:0]      mk;
    dims_t           r;
    emit = 1'b0;
    r = make_dims(1'b0, FmtNone, '0, '0);
    if (!file_done) begin
      p = byte_pos;
      if (p < MinSize) hdr_bytes[p] = b;
      for (int i = 0; i < ChunkHdr - 1; i++) chunk_win[i] = chunk_win[i + 1];
      chunk_win[ChunkHdr - 1] = b;
      gif_ok  = 1'b1;
      png_ok  = 1'b1;
      jpeg_ok = 1'b1;
      for (int i = 0; i < 16; i++) begin
        if (i <= p) begin
          if (i < 3) begin
            if (hdr_bytes[i] != GifSig[8*(2-i) +: 8]) gif_ok = 1'b0;
            if (hdr_bytes[i] != JpegSig[8*(2-i) +: 8]) jpeg_ok = 1'b0;
          end
          if (PngCare[15-i] && hdr_bytes[i] != PngSig[8*(15-i) +: 8]) png_ok = 1'b0;
        end
      end
      if (p < MinSize && !gif_ok && !png_ok && !jpeg_ok) begin
        emit = 1'b1;
      end else begin
        if (jpeg_ok && p >= 2 && !sof_held && p == chunk_start + ChunkHdr - 1) begin
          mk = chunk_win[1];
          if (chunk_win[0] != MarkerPrefix) begin
            emit = 1'b1;
          end else if (mk >= MarkerSof0 && mk <= MarkerSofF && mk != MarkerDht &&
                       mk != MarkerJpg && mk != MarkerDac) begin
            if (p >= MinSize - 1) begin
              emit = 1'b1;
              r = make_dims(1'b1, FmtJpeg, {16'h0, chunk_win[7], chunk_win[8]},
                            {16'h0, chunk_win[5], chunk_win[6]});
            end else begin
              sof_held = 1'b1;
              held_w   = {chunk_win[7], chunk_win[8]};
              held_h   = {chunk_win[5], chunk_win[6]};
            end
          end else begin
            if (mk >= MarkerRst0 && mk <= MarkerEoi) span = 0;
            else if (mk == MarkerDri) span = 4;
            else span = {chunk_win[2], chunk_win[3]};
            nxt = chunk_start + 2 + span;
            if (nxt + ChunkHdr - 1 > PosMax - 1) emit = 1'b1;
            else chunk_start = nxt;
          end
        end
        if (!emit && p == MinSize - 1) begin
          if (jpeg_ok) begin
            if (sof_held) begin
              emit = 1'b1;
              r = make_dims(1'b1, FmtJpeg, {16'h0, held_w}, {16'h0, held_h});
            end
          end else if (gif_ok) begin
            emit = 1'b1;
            r = make_dims(1'b1, FmtGif, {16'h0, hdr_bytes[7], hdr_bytes[6]},
                          {16'h0, hdr_bytes[9], hdr_bytes[8]});
          end else if (png_ok) begin
            emit = 1'b1;
            r = make_dims(1'b1, FmtPng,
                          {hdr_bytes[16], hdr_bytes[17], hdr_bytes[18], hdr_bytes[19]},
                          {hdr_bytes[20], hdr_bytes[21], hdr_bytes[22], hdr_bytes[23]});
          end else begin
            emit = 1'b1;
          end
        end
      end
    end
    if (l) begin
      if (!file_done && !emit) emit = 1'b1;
      restart_file();
    end else begin
      if (emit) file_done = 1'b1;
      if (byte_pos < PosMax) byte_pos++;
    end
    if (emit) dims_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dims_t want;
    dims_t got;
    if (!rst_ni) begin
      restart_file();
      for (int i = 0; i < MinSize; i++) hdr_bytes[i] = '0;
      for (int i = 0; i < ChunkHdr; i++) chunk_win[i] = '0;
      dims_q.delete();
      err_count = 0;
      mismatches_o <= 0;
      pending_results_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) predict_byte(data_byte_i, last_byte_i);
      if (out_valid_i && out_ready_i) begin
        got = make_dims(found_i, fmt_e'(image_format_i), image_width_i, image_height_i);
        if (dims_q.size() == 0) begin
          err_count++;
          $display("%0t: expected no result, actual found=%0d format=%0d width=%0d height=%0d",
                   $time, got.found, got.fmt, got.width, got.height);
        end else begin
          want = dims_q.pop_front();
          if (got !== want) begin
            err_count++;
            $display("%0t: result mismatch expected %s, actual %s", $time,
                     $sformatf("found=%0d format=%0d width=%0d height=%0d",
                               want.found, want.fmt, want.width, want.height),
                     $sformatf("found=%0d format=%0d width=%0d height=%0d",
                               got.found, got.fmt, got.width, got.height));
          end
        end
      end
      mismatches_o <= err_count;
      pending_results_o <= dims_q.size();
    end
  end

endmodule

// ===== sim/image_header_dimension_parser_top_test.sv =====
// image_header_dimension_parser_top_test.sv
// stimulus and verdict for image_header_dimension_parser_top: directed and random gif,
// png, jpeg and noise files; depends on ihdp_pkg and ihdp_result_checker
module image_header_dimension_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ihdp_pkg::*;

  localparam int CycleLimit = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        found_o;
  logic [1:0]  image_format_o;
  logic [31:0] image_width_o;
  logic [31:0] image_height_o;

  int unsigned mismatches;
  int unsigned pending_results;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          bytes_sent = 0;
  int          files_sent = 0;
  int          cycle_count = 0;
  logic [7:0]  file_q [$];

  image_header_dimension_parser_top DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .last_byte_i,
    .out_valid_o,
    .out_ready_i,
    .found_o,
    .image_format_o,
    .image_width_o,
    .image_height_o
  );

  ihdp_result_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i        (in_ready_o),
    .data_byte_i,
    .last_byte_i,
    .out_valid_i       (out_valid_o),
    .out_ready_i,
    .found_i           (found_o),
    .image_format_i    (image_format_o),
    .image_width_i     (image_width_o),
    .image_height_i    (image_height_o),
    .mismatches_o      (mismatches),
    .pending_results_o (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** image_header_dimension_parser_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(65535));
      default: return $urandom;
    endcase
  endfunction

  task automatic add_random(input int n);
    repeat (n) file_q.push_back(8'($urandom));
  endtask

  task automatic trim_file(input int len);
    while (file_q.size() > len) file_q.delete(file_q.size() - 1);
  endtask

  task automatic build_gif(input logic [15:0] w, input logic [15:0] h, input int len);
    file_q.delete();
    file_q.push_back(8'h47);
    file_q.push_back(8'h49);
    file_q.push_back(8'h46);
    file_q.push_back(8'h38);
    file_q.push_back($urandom_range(1) ? 8'h39 : 8'h37);
    file_q.push_back(8'h61);
    file_q.push_back(w[7:0]);
    file_q.push_back(w[15:8]);
    file_q.push_back(h[7:0]);
    file_q.push_back(h[15:8]);
    add_random((len > 10) ? len - 10 : 0);
    trim_file(len);
  endtask

  task automatic build_png(input logic [31:0] w, input logic [31:0] h, input int len);
    file_q = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
               8'h00, 8'h00, 8'h00, 8'h0D, 8'h49, 8'h48, 8'h44, 8'h52};
    for (int i = 3; i >= 0; i--) file_q.push_back(w[8*i +: 8]);
    for (int i = 3; i >= 0; i--) file_q.push_back(h[8*i +: 8]);
    add_random((len > 24) ? len - 24 : 0);
    trim_file(len);
  endtask

  task automatic add_sof(input logic [7:0] mk, input logic [15:0] h, input logic [15:0] w);
    file_q.push_back(MarkerPrefix);
    file_q.push_back(mk);
    file_q.push_back(8'h00);
    file_q.push_back(8'h11);
    file_q.push_back(8'h08);
    file_q.push_back(h[15:8]);
    file_q.push_back(h[7:0]);
    file_q.push_back(w[15:8]);
    file_q.push_back(w[7:0]);
    add_random(8);
  endtask

  task automatic add_segment(input logic [7:0] mk, input int span);
    file_q.push_back(MarkerPrefix);
    file_q.push_back(mk);
    file_q.push_back(8'(span >> 8));
    file_q.push_back(8'(span));
    add_random((span < 2) ? 0 : ((span > 40) ? 20 : span - 2));
  endtask

  task automatic build_jpeg();
    int         starts [$];
    int         span;
    logic [3:0] nib;
    logic [7:0] mk;
    file_q = '{8'hFF, 8'hD8};
    repeat ($urandom_range(4)) begin
      starts.push_back(file_q.size());
      case ($urandom_range(3))
        0: begin
          file_q.push_back(MarkerPrefix);
          file_q.push_back(8'($urandom_range(MarkerEoi, MarkerRst0)));
        end
        1: begin
          file_q.push_back(MarkerPrefix);
          file_q.push_back(MarkerDri);
          add_random(4);
        end
        default: begin
          case ($urandom_range(5))
            0:       mk = MarkerDht;
            1:       mk = MarkerJpg;
            2:       mk = MarkerDac;
            3:       mk = 8'hE0 | 8'($urandom_range(15));
            4:       mk = $urandom_range(1) ? 8'hDB : 8'hFE;
            default: mk = 8'($urandom);
          endcase
          span = ($urandom_range(15) == 0) ? $urandom_range(65535) : $urandom_range(40, 2);
          add_segment(mk, span);
        end
      endcase
    end
    if ($urandom_range(7) != 0) begin
      starts.push_back(file_q.size());
      do nib = 4'($urandom_range(15)); while (nib == 4'h4 || nib == 4'h8 || nib == 4'hC);
      add_sof({4'hC, nib}, pick16(), pick16());
    end else begin
      file_q.push_back(MarkerPrefix);
      file_q.push_back(MarkerEoi);
    end
    add_random($urandom_range(6));
    if ($urandom_range(9) == 0 && starts.size() > 1)
      file_q[starts[$urandom_range(starts.size() - 1, 1)]] = 8'($urandom_range(254));
    if ($urandom_range(7) == 0) trim_file($urandom_range(file_q.size(), 1));
  endtask

  task automatic build_noise();
    case ($urandom_range(3))
      0: file_q.delete();
      1: file_q = '{8'h47, 8'h49};
      2: file_q = '{8'h89, 8'h50, 8'h4E, 8'h47};
      default: file_q = '{8'hFF, 8'hD8};
    endcase
    add_random(30);
    trim_file($urandom_range(30, 1));
  endtask

  task automatic build_random_file();
    int pick;
    int len;
    pick = $urandom_range(99);
    len = ($urandom_range(5) == 0) ? $urandom_range(23, 1) : $urandom_range(40, 24);
    if (pick < 22) build_gif(pick16(), pick16(), len);
    else if (pick < 44) build_png(pick32(), pick32(), len);
    else if (pick < 82) build_jpeg();
    else build_noise();
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= l;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
    bytes_sent += file_q.size();
    files_sent++;
  endtask

  initial begin
    int byte_mark;
    int file_mark;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    out_ready_i = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 32;
    recv_idle = 55;
    // single byte file
    file_q = '{8'h00};
    send_file();
    // gif and png of exactly 24 bytes with extreme sizes
    build_gif(16'hFFFF, 16'h0000, 24);
    send_file();
    build_png(32'hFFFF_FFFF, 32'h0000_0000, 24);
    send_file();
    // sof ahead of byte 24, held until then
    file_q = '{8'hFF, 8'hD8};
    add_sof(MarkerSof0, 16'h0001, 16'hFFFF);
    add_random(5);
    send_file();
    // same, but the file ends before byte 24
    file_q = '{8'hFF, 8'hD8};
    add_sof(MarkerSofF, 16'h8000, 16'h0080);
    trim_file(20);
    send_file();
    // second chunk without its 0xff prefix
    file_q = '{8'hFF, 8'hD8, 8'hFF, MarkerRst0, 8'h00};
    add_random(15);
    send_file();
    // broken gif signature, remaining bytes ignored
    file_q = '{8'h47, 8'h49, 8'h58};
    add_random(5);
    send_file();
    // png with a broken ihdr tag
    build_png(32'h0000_0001, 32'h8000_0000, 30);
    file_q[13] = 8'h00;
    send_file();
    // gif one byte short
    build_gif(16'h1234, 16'h5678, 23);
    send_file();
    // full walk: eoi, dri, dht, then a late sof
    file_q = '{8'hFF, 8'hD8, 8'hFF, MarkerEoi, 8'hFF, MarkerDri};
    add_random(4);
    add_segment(MarkerDht, 16);
    add_sof(8'hC2, 16'h0300, 16'h0400);
    add_random(3);
    send_file();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 32;
          recv_idle = 55;
        end
        1: begin
          send_idle = 55;
          recv_idle = 32;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      byte_mark = bytes_sent;
      file_mark = files_sent;
      while (bytes_sent - byte_mark < 400 || files_sent - file_mark < 16) begin
        build_random_file();
        send_file();
      end
    end
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (pending_results != 0);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_results == 0)
      $display("** image_header_dimension_parser_top: PASSED **");
    else
      $display("** image_header_dimension_parser_top: FAILED **");
    $finish;
  end

endmodule

// ===== image_header_dimension_parser_top.f =====
+incdir+rtl
rtl/ihdp_pkg.sv
rtl/image_header_dimension_parser_top.sv
rtl/ihdp_checker.sv
sim/ihdp_result_checker.sv
sim/image_header_dimension_parser_top_test.sv
